FILE: design/bba_pkg.sv
// Shared constants, payload types and controller/datapath signal groups of the block allocator.
package bba_pkg;

  localparam int MaxBlocks = 256;
  localparam int AddrW     = 32;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);
  localparam int RowBits   = 8;
  localparam int RowIdxW   = $clog2(RowBits);
  localparam int NumRows   = MaxBlocks / RowBits;
  localparam int RowW      = $clog2(NumRows);
  localparam int ReqW      = 16;
  localparam int ElemW     = 16;
  localparam int EbyteW    = 4;
  localparam int BlocksW   = 9;
  localparam int NumW      = 8;
  localparam int BlkSizeW  = ElemW + EbyteW;
  localparam int DivW      = BlkSizeW + IdxW;
  localparam int StepW     = $clog2(IdxW);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StRefused     = 2'd1,
    StInvalid     = 2'd2,
    StAlreadyFree = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBase,
    CfgBlocks,
    CfgElems,
    CfgElemBytes
  } cfg_reg_e;

  typedef struct packed {
    logic            command;
    logic [ReqW-1:0] request_elements;
    logic [AddrW-1:0] release_address;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] block_address;
    logic [NumW-1:0]  block_number;
    logic [CntW-1:0]  free_count;
  } out_t;

  typedef struct packed {
    logic    capture;
    logic    scan_start;
    logic    scan_step;
    logic    alloc_take;
    logic    mul;
    logic    add;
    logic    div_init;
    logic    div_step;
    logic    free_read;
    logic    free_update;
    logic    reject;
    status_e rej_status;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic alloc_ok;
    logic range_ok;
    logic found;
    logic div_last;
    logic div_ok;
  } dp_stat_t;

endpackage

FILE: design/bba_ctrl.sv
// Sequencing state machine of the block allocator.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FREE_CHK,
    S_FREE_UPD,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        if (stat_i.is_free) begin
          if (stat_i.range_ok) begin
            cmd_o.div_init = 1'b1;
            state_d        = S_DIV;
          end else begin
            cmd_o.reject     = 1'b1;
            cmd_o.rej_status = StInvalid;
            state_d          = S_FINISH;
          end
        end else begin
          if (stat_i.alloc_ok) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.reject     = 1'b1;
            cmd_o.rej_status = StRefused;
            state_d          = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.found) begin
          cmd_o.alloc_take = 1'b1;
          state_d          = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_FINISH;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (stat_i.div_ok) begin
          cmd_o.free_read = 1'b1;
          state_d         = S_FREE_UPD;
        end else begin
          cmd_o.reject     = 1'b1;
          cmd_o.rej_status = StInvalid;
          state_d          = S_FINISH;
        end
      end
      S_FREE_UPD: begin
        cmd_o.free_update = 1'b1;
        state_d           = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/bba_datapath.sv
// Registers, free map memory, search, divider and address arithmetic of the block allocator.
module bba_datapath import bba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_t                 in_data_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  output out_t                out_data_o
);

  function automatic logic [CntW-1:0] live_of(input logic [BlocksW-1:0] b);
    logic [CntW-1:0] n;
    n = CntW'(b);
    if (n > CntW'(MaxBlocks)) begin
      n = CntW'(MaxBlocks);
    end
    return n;
  endfunction

  // A row never written since the last pool reset holds ones for blocks below the live count.
  function automatic logic [RowBits-1:0] init_row(input logic [RowW-1:0] row,
                                                  input logic [CntW-1:0] n);
    logic [RowBits-1:0] r;
    logic [IdxW-1:0]    idx;
    r = '0;
    for (int i = 0; i < RowBits; i++) begin
      idx  = {row, RowIdxW'(i)};
      r[i] = (CntW'(idx) < n);
    end
    return r;
  endfunction

  logic [AddrW-1:0]    base_q;
  logic [BlocksW-1:0]  blocks_q;
  logic [ElemW-1:0]    elems_q;
  logic [EbyteW-1:0]   ebytes_q;
  logic [CntW-1:0]     free_blocks_q;
  logic [NumRows-1:0]  row_valid_q;

  logic                is_free_q;
  logic [ReqW-1:0]     req_q;
  logic [AddrW-1:0]    rel_q;
  logic [AddrW-1:0]    diff_q;
  logic                ge_q;
  logic [BlkSizeW-1:0] bsize_q;
  logic [RowW-1:0]     scan_row_q;
  logic [RowBits-1:0]  rd_data_q;
  logic                rd_vld_q;
  logic [RowW-1:0]     rd_row_q;
  logic [IdxW-1:0]     idx_q;
  logic [DivW-1:0]     prod_q;
  logic [DivW-1:0]     rem_q;
  logic [DivW-1:0]     dvs_q;
  logic [IdxW-1:0]     quot_q;
  logic [StepW-1:0]    step_q;
  status_e             res_status_q;
  logic [AddrW-1:0]    res_addr_q;
  logic [NumW-1:0]     res_num_q;
  out_t                out_q;

  logic [RowBits-1:0]  map_mem [NumRows];

  logic [CntW-1:0]     live;
  logic [RowBits-1:0]  eff;
  logic [RowIdxW-1:0]  pos;
  logic [RowIdxW-1:0]  fbit;
  logic                fbit_set;
  logic                found;
  logic                rd_en;
  logic [RowW-1:0]     rd_addr;
  logic                wr_en;
  logic [RowBits-1:0]  wr_data;
  logic                take;
  logic                release_blk;
  logic                div_ge;

  assign live     = live_of(blocks_q);
  assign eff      = rd_vld_q ? rd_data_q : init_row(rd_row_q, live);
  assign found    = |eff;
  assign fbit     = quot_q[RowIdxW-1:0];
  assign fbit_set = eff[fbit];
  assign div_ge   = (rem_q >= dvs_q);

  always_comb begin
    pos = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (eff[i]) begin
        pos = RowIdxW'(i);
      end
    end
  end

  assign take        = cmd_i.alloc_take && found;
  assign release_blk = cmd_i.free_update && !fbit_set;

  always_comb begin
    rd_en   = cmd_i.scan_start || cmd_i.scan_step || cmd_i.free_read;
    rd_addr = '0;
    if (cmd_i.scan_step) begin
      rd_addr = scan_row_q;
    end else if (cmd_i.free_read) begin
      rd_addr = quot_q[IdxW-1:RowIdxW];
    end
  end

  always_comb begin
    wr_en   = take || release_blk;
    wr_data = eff | (RowBits'(1) << fbit);
    if (cmd_i.alloc_take) begin
      wr_data = eff & ~(RowBits'(1) << pos);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[rd_row_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= map_mem[rd_addr];
      rd_vld_q  <= row_valid_q[rd_addr];
      rd_row_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= '0;
      blocks_q      <= BlocksW'(MaxBlocks);
      elems_q       <= ElemW'(16);
      ebytes_q      <= EbyteW'(1);
      free_blocks_q <= CntW'(MaxBlocks);
      row_valid_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgBase: begin
          base_q <= cfg_data_i[AddrW-1:0];
        end
        CfgBlocks: begin
          blocks_q      <= cfg_data_i[BlocksW-1:0];
          free_blocks_q <= live_of(cfg_data_i[BlocksW-1:0]);
          row_valid_q   <= '0;
        end
        CfgElems: begin
          elems_q <= cfg_data_i[ElemW-1:0];
        end
        CfgElemBytes: begin
          ebytes_q <= cfg_data_i[EbyteW-1:0];
        end
        default: begin
        end
      endcase
    end else begin
      if (wr_en) begin
        row_valid_q[rd_row_q] <= 1'b1;
      end
      if (take) begin
        free_blocks_q <= free_blocks_q - CntW'(1);
      end else if (release_blk) begin
        free_blocks_q <= free_blocks_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_free_q <= (in_data_i.command == CmdFree);
      req_q     <= in_data_i.request_elements;
      rel_q     <= in_data_i.release_address;
      diff_q    <= in_data_i.release_address - base_q;
      ge_q      <= (in_data_i.release_address >= base_q);
      bsize_q   <= BlkSizeW'(elems_q) * BlkSizeW'(ebytes_q);
    end
    if (cmd_i.scan_start) begin
      scan_row_q <= RowW'(1);
    end else if (cmd_i.scan_step) begin
      scan_row_q <= scan_row_q + RowW'(1);
    end
    if (take) begin
      idx_q        <= {rd_row_q, pos};
      res_status_q <= StOk;
      res_num_q    <= NumW'({rd_row_q, pos});
    end
    if (cmd_i.mul) begin
      prod_q <= DivW'(idx_q) * DivW'(bsize_q);
    end
    if (cmd_i.add) begin
      res_addr_q <= base_q + AddrW'(prod_q);
    end
    if (cmd_i.div_init) begin
      rem_q  <= diff_q[DivW-1:0];
      dvs_q  <= DivW'(bsize_q) << (IdxW - 1);
      quot_q <= '0;
      step_q <= StepW'(IdxW - 1);
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      quot_q <= {quot_q[IdxW-2:0], div_ge};
      dvs_q  <= dvs_q >> 1;
      step_q <= step_q - StepW'(1);
    end
    if (cmd_i.free_update) begin
      res_addr_q   <= rel_q;
      res_num_q    <= NumW'(quot_q);
      res_status_q <= fbit_set ? StAlreadyFree : StOk;
    end
    if (cmd_i.reject) begin
      res_status_q <= cmd_i.rej_status;
      res_addr_q   <= '0;
      res_num_q    <= '0;
    end
    if (cmd_i.load_out) begin
      out_q.status        <= res_status_q;
      out_q.block_address <= res_addr_q;
      out_q.block_number  <= res_num_q;
      out_q.free_count    <= free_blocks_q;
    end
  end

  always_comb begin
    stat_o.is_free  = is_free_q;
    stat_o.alloc_ok = (free_blocks_q != '0) && (req_q <= elems_q);
    stat_o.range_ok = ge_q && (bsize_q != '0) && (diff_q < AddrW'({bsize_q, IdxW'(0)}));
    stat_o.found    = found;
    stat_o.div_last = (step_q == '0);
    stat_o.div_ok   = (rem_q == '0) && (CntW'(quot_q) < live);
  end

  assign out_data_o = out_q;

endmodule

FILE: design/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
// The block hands out and takes back equal-size blocks of a pool, one bit per block.
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one request per
// transaction: allocate the lowest free block, or free the block at an address.
// The output channel (out_valid_o, out_ready_i, out_data_o) returns one result per
// request: status, block address, block number and the count of free blocks left.
// Requests are handled one at a time. An allocation searches r (1 to 32) eight-block
// map rows for the lowest free block, one row per cycle from the map memory. A free
// runs the eight steps of the block-index divider. A request may be refused at once;
// a free may also be rejected after the divide, as misaligned or past the last block.
// The next request is accepted in the cycle after a result is loaded into the output
// register, even while that result still waits for out_ready_i; a stalled receiver
// holds the block only when a second result is ready to be loaded.
// Reset marks every block free and sets 256 blocks of 16 one-byte elements at address 0.
// Writing the block count through cfg_we_i marks every block free again; no clearing
// pass is needed, so the block accepts requests right after reset.
module bitmap_block_allocator import bba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bba_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  a_reject_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StRefused || out_data_o.status == StInvalid))
    |-> (out_data_o.block_address == '0 && out_data_o.block_number == '0))
    else $error("rejected request returned a nonzero address or number");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.free_count <= CntW'(MaxBlocks)))
    else $error("free block count exceeds pool size");
`endif

endmodule

FILE: tb/bba_allocation_checker.sv
// Checker that mirrors the allocator's free map and compares every result with its prediction.
module bba_allocation_checker import bba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_t                out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output logic [3:0][31:0]    status_tally_o
);

  logic [MaxBlocks-1:0] free_map;
  logic [CntW-1:0]      free_left;
  logic [AddrW-1:0]     pool_base;
  logic [BlocksW-1:0]   pool_blocks;
  logic [ElemW-1:0]     blk_elems;
  logic [EbyteW-1:0]    elem_size;
  out_t                 awaited_results[$];
  int                   failures;
  logic [3:0][31:0]     tally;

  function automatic int unsigned managed_blocks();
    return (pool_blocks > MaxBlocks) ? MaxBlocks : pool_blocks;
  endfunction

  function automatic void clear_map();
    int unsigned n;
    int i;
    n = managed_blocks();
    for (i = 0; i < MaxBlocks; i++) begin
      free_map[i] = (i < n);
    end
    free_left = n[CntW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] block_addr(input int unsigned idx,
                                                  input logic [BlkSizeW-1:0] bsize);
    logic [AddrW-1:0] addr;
    addr = pool_base + AddrW'(idx) * AddrW'(bsize);
    return addr;
  endfunction

  function automatic out_t serve_request(input in_t req);
    out_t                res;
    int unsigned         n;
    int unsigned         idx;
    int                  i;
    bit                  found;
    logic [BlkSizeW-1:0] bsize;
    logic [AddrW-1:0]    offset;
    n      = managed_blocks();
    bsize  = blk_elems * elem_size;
    res    = '0;
    res.status = StOk;
    found  = 1'b0;
    idx    = 0;
    if (req.command == CmdAlloc) begin
      if (free_left != 0 && req.request_elements <= blk_elems) begin
        for (i = 0; i < n && !found; i++) begin
          if (free_map[i]) begin
            found = 1'b1;
            idx   = i;
          end
        end
      end
      if (found) begin
        free_map[idx]     = 1'b0;
        free_left         = free_left - 1'b1;
        res.block_address = block_addr(idx, bsize);
        res.block_number  = idx[NumW-1:0];
      end else begin
        res.status = StRefused;
      end
    end else begin
      offset = req.release_address - pool_base;
      if (bsize == 0 || req.release_address < pool_base) begin
        res.status = StInvalid;
      end else if ((offset % bsize) != 0 || (offset / bsize) >= n) begin
        res.status = StInvalid;
      end else begin
        idx               = offset / bsize;
        res.block_number  = idx[NumW-1:0];
        res.block_address = block_addr(idx, bsize);
        if (free_map[idx]) begin
          res.status = StAlreadyFree;
        end else begin
          free_map[idx] = 1'b1;
          free_left     = free_left + 1'b1;
        end
      end
    end
    res.free_count = free_left;
    return res;
  endfunction

  function automatic bit field_differs(input string field, input logic [AddrW-1:0] want,
                                       input logic [AddrW-1:0] seen);
    if (want === seen) return 1'b0;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, seen);
    return 1'b1;
  endfunction

  function automatic void check_result(input out_t seen);
    out_t want;
    bit   bad;
    if (awaited_results.size() == 0) begin
      $display("%0t: result with no request pending, expected none, got 0x%0h", $time, seen);
      failures++;
      return;
    end
    want = awaited_results.pop_front();
    bad  = field_differs("status", want.status, seen.status)
         | field_differs("block_address", want.block_address, seen.block_address)
         | field_differs("block_number", want.block_number, seen.block_number)
         | field_differs("free_count", want.free_count, seen.free_count);
    if (bad) failures++;
    tally[want.status] = tally[want.status] + 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base   = '0;
      pool_blocks = BlocksW'(MaxBlocks);
      blk_elems   = ElemW'(16);
      elem_size   = EbyteW'(1);
      clear_map();
      awaited_results.delete();
      failures = 0;
      tally    = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgBase: pool_base = cfg_data_i[AddrW-1:0];
          CfgBlocks: begin
            pool_blocks = cfg_data_i[BlocksW-1:0];
            clear_map();
          end
          CfgElems: blk_elems = cfg_data_i[ElemW-1:0];
          CfgElemBytes: elem_size = cfg_data_i[EbyteW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) awaited_results.push_back(serve_request(in_data_i));
    end
    fail_count_o   <= failures;
    pending_o      <= awaited_results.size();
    status_tally_o <= tally;
  end

endmodule

FILE: tb/tb_bitmap_block_allocator.sv
// Testbench top for the bitmap block allocator: stimulus, receiver, watchdog and verdict.
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int RandomPhases  = 8;
  localparam int SqueezeCycles = 300;
  localparam int StallLimit    = 3000;
  localparam int EndCycles     = 40;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  int                  fail_count;
  int                  pending;
  logic [3:0][31:0]    status_tally;

  bit                  steady;
  int                  squeeze_wanted;
  int                  squeeze_served;
  int                  sent_count;
  int                  settings_used;
  int unsigned         allocs_since_clear;
  logic [AddrW-1:0]    cur_base;
  logic [BlocksW-1:0]  cur_blocks;
  logic [ElemW-1:0]    cur_elems;
  logic [EbyteW-1:0]   cur_ebytes;

  bitmap_block_allocator i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  bba_allocation_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .status_tally_o(status_tally)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_request(input in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (req.command == CmdAlloc) allocs_since_clear++;
  endtask

  task automatic alloc_req(input logic [ReqW-1:0] elems);
    in_t req;
    req.command          = CmdAlloc;
    req.request_elements = elems;
    req.release_address  = $urandom;
    push_request(req);
  endtask

  task automatic free_req(input logic [AddrW-1:0] addr);
    in_t req;
    req.command          = CmdFree;
    req.request_elements = $urandom;
    req.release_address  = addr;
    push_request(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Narrow registers get random upper data bits, which the block must ignore.
  task automatic config_pool(input logic [AddrW-1:0] b, input logic [BlocksW-1:0] nb,
                             input logic [ElemW-1:0] ne, input logic [EbyteW-1:0] eb);
    logic [CfgDataW-1:0] data;
    put_reg(CfgBase, b);
    data = $urandom;
    data[ElemW-1:0] = ne;
    put_reg(CfgElems, data);
    data = $urandom;
    data[EbyteW-1:0] = eb;
    put_reg(CfgElemBytes, data);
    data = $urandom;
    data[BlocksW-1:0] = nb;
    put_reg(CfgBlocks, data);
    cfg_we <= 1'b0;
    cur_base           = b;
    cur_blocks         = nb;
    cur_elems          = ne;
    cur_ebytes         = eb;
    allocs_since_clear = 0;
    settings_used++;
  endtask

  task automatic random_pool(input bit fill);
    logic [AddrW-1:0]   b;
    logic [BlocksW-1:0] nb;
    logic [ElemW-1:0]   ne;
    logic [EbyteW-1:0]  eb;
    int                 r;
    r = $urandom_range(0, 9);
    if (r < 3) b = '0;
    else if (r < 7) b = $urandom;
    else b = 32'hFFFF_FFFF - $urandom_range(0, 4095);
    r = $urandom_range(0, 19);
    if (fill) nb = BlocksW'(MaxBlocks);
    else if (r < 6) nb = $urandom_range(1, 16);
    else if (r < 13) nb = $urandom_range(17, 255);
    else if (r < 16) nb = BlocksW'(MaxBlocks);
    else if (r < 19) nb = $urandom_range(257, 511);
    else nb = '0;
    r = $urandom_range(0, 19);
    if (r < 12) ne = $urandom_range(1, 64);
    else if (r < 17) ne = $urandom;
    else if (r < 19) ne = 16'hFFFF;
    else ne = '0;
    r = $urandom_range(0, 19);
    if (r < 17) eb = $urandom_range(1, 8);
    else if (r < 19) eb = $urandom_range(9, 15);
    else eb = '0;
    config_pool(b, nb, ne, eb);
  endtask

  // Frees mostly target blocks that can be in use: the lowest-free policy keeps every
  // used block below the number of allocations since the map was last cleared.
  function automatic in_t random_request(input int alloc_pct);
    in_t              req;
    int unsigned      n;
    int unsigned      span;
    logic [AddrW-1:0] bsize;
    logic [AddrW-1:0] slot;
    int               r;
    req.request_elements = $urandom;
    req.release_address  = $urandom;
    n     = (cur_blocks > MaxBlocks) ? MaxBlocks : cur_blocks;
    bsize = cur_elems * cur_ebytes;
    span  = (allocs_since_clear < n) ? allocs_since_clear : n;
    if (span == 0) span = n;
    slot  = cur_base + ((n > 0) ? $urandom_range(0, span - 1) : 0) * bsize;
    if ($urandom_range(0, 99) < alloc_pct) begin
      req.command = CmdAlloc;
      r = $urandom_range(0, 9);
      if (r < 8) req.request_elements = $urandom_range(0, cur_elems);
      else if (r < 9) req.request_elements = cur_elems + 1'b1;
    end else begin
      req.command = CmdFree;
      r = $urandom_range(0, 99);
      if (r < 75) req.release_address = slot;
      else if (r < 85 && bsize > 1) req.release_address = slot + $urandom_range(1, bsize - 1);
      else if (r < 92) req.release_address = cur_base + (n + $urandom_range(0, 3)) * bsize;
      else if (r < 96) req.release_address = cur_base - $urandom_range(1, 64);
    end
    return req;
  endfunction

  initial begin
    int stall;
    squeeze_served = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_wanted > squeeze_served) begin
        out_ready <= 1'b0;
        repeat (SqueezeCycles) @(posedge clk);
        squeeze_served++;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
             StallLimit, pending);
    $display("bitmap_block_allocator regression: fail");
    $finish;
  end

  initial begin
    int phase;
    int item;
    int alloc_pct;
    int phase_items;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CfgBase;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    steady             = 1'b0;
    squeeze_wanted     = 0;
    sent_count         = 0;
    settings_used      = 1;
    allocs_since_clear = 0;
    cur_base           = '0;
    cur_blocks         = BlocksW'(MaxBlocks);
    cur_elems          = ElemW'(16);
    cur_ebytes         = EbyteW'(1);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pool: capacity limits, double free, misaligned and out-of-range frees.
    alloc_req(16'd0);
    alloc_req(16'd16);
    alloc_req(16'd17);
    alloc_req(16'hFFFF);
    free_req(32'h10);
    free_req(32'h10);
    free_req(32'h11);
    free_req(32'h1000);
    free_req(32'hFFFF_FFFF);

    // Moving the base alone must leave the map as it was.
    drain();
    put_reg(CfgBase, 32'h100);
    cfg_we <= 1'b0;
    cur_base = 32'h100;
    free_req(32'h80);
    free_req(32'h100);
    alloc_req(16'd5);

    // Tiny pool with a block size that is not a power of two, run until exhausted.
    drain();
    config_pool(32'h1000, 9'd3, 16'd3, 4'd5);
    repeat (4) alloc_req(16'd3);
    free_req(32'h1000 + 32'd15);
    alloc_req(16'd3);

    // Oversized block count, largest blocks and addresses that wrap around.
    drain();
    config_pool(32'hFFFF_FFF0, 9'h1FF, 16'hFFFF, 4'd8);
    alloc_req(16'hFFFF);
    alloc_req(16'd1);
    free_req(32'hFFFF_FFF0 + 32'd255 * 32'd524280);
    free_req(32'hFFFF_FFF0 + 32'd256 * 32'd524280);

    // Zero block size, then an empty pool.
    drain();
    config_pool(32'h40, 9'd2, 16'd7, 4'd0);
    repeat (2) alloc_req(16'd7);
    free_req(32'h40);
    drain();
    config_pool(32'h40, 9'd0, 16'd0, 4'd4);
    alloc_req(16'd0);
    free_req(32'h40);

    for (phase = 0; phase < RandomPhases; phase++) begin
      drain();
      random_pool(phase == 0);
      steady      = (phase % 3 == 1);
      alloc_pct   = (phase == 0) ? 95 : $urandom_range(35, 75);
      phase_items = (phase == 0) ? 300 : 92;
      for (item = 0; item < phase_items; item++) begin
        if (phase == 2 && item == 30) squeeze_wanted++;
        push_request(random_request(alloc_pct));
      end
    end

    drain();
    repeat (EndCycles) @(posedge clk);
    $display("Ran %0d requests over %0d pool settings, with one long output stall.",
             sent_count, settings_used);
    $display("Results: %0d ok, %0d refused, %0d invalid address, %0d already free.",
             status_tally[StOk], status_tally[StRefused], status_tally[StInvalid],
             status_tally[StAlreadyFree]);
    if (fail_count == 0 && pending == 0) begin
      $display("bitmap_block_allocator regression: pass");
    end else begin
      $display("%0d mismatched results, %0d results never arrived.", fail_count, pending);
      $display("bitmap_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
